### src/fct_pkg.sv
`timescale 1ns / 1ps
package fct_pkg;
	localparam int CONTEXTS = 64;
	localparam int BUCKETS = 512;
	localparam logic [63:0] HASH_MUL = 64'd11400714819323198485;
	localparam logic [31:0] HASH_MUL_LO = HASH_MUL[31:0];
	localparam logic [31:0] HASH_MUL_HI = HASH_MUL[63:32];
	localparam int HASH_SHIFT = 55;
	localparam logic [1:0] FUNC_OBSERVE = 2'd0;
	localparam logic [1:0] FUNC_RELEASE = 2'd1;
	localparam logic [1:0] FUNC_FLUSH = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic REG_IDLE_TIMEOUT = 1'b0;
	localparam logic REG_BYTE_BUDGET = 1'b1;
	localparam logic [31:0] IDLE_TIMEOUT_RESET = 32'd300000000;
	localparam logic [15:0] BYTE_BUDGET_RESET = 16'd4096;

	// record of one table entry
	typedef struct packed {
		logic [63:0] flow_id;
		logic [62:0] last_seen;
		logic [15:0] length;
		logic        clipped;
		logic [63:0] order;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan_clear;
		logic scan_step;
		logic hash_step;
		logic find_step;
		logic recl_step;
		logic evict_old;
		logic commit;
		logic release_hit;
		logic flush;
		logic res_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
		logic hit;
		logic full;
		logic free_found;
		logic old_found;
	} sts_t;
endpackage

### src/fct_ram.sv
`timescale 1ns / 1ps
module fct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### src/fct_ctrl.sv
`timescale 1ns / 1ps
module fct_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    func,
	input  logic [15:0]   byte_count,
	output logic          out_valid,
	input  logic          out_stall,
	output fct_pkg::cmd_t cmd,
	input  fct_pkg::sts_t sts
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FIND = 4'd1;
	localparam logic [3:0] S_HASH = 4'd2;
	localparam logic [3:0] S_RECL = 4'd3;
	localparam logic [3:0] S_OLD  = 4'd4;
	localparam logic [3:0] S_FREE = 4'd5;
	localparam logic [3:0] S_DONE = 4'd6;
	localparam logic [3:0] S_HASHN = 4'd7;

	logic [3:0] state_q;
	logic [1:0] func_q;
	logic       res_pend;

	assign res_pend = out_valid && out_stall;
	assign in_stall = (state_q != S_IDLE) || res_pend;

	// sequencer over the entry walks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			func_q <= 2'd0;
		end else begin
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						func_q <= func;
						if (func == fct_pkg::FUNC_FLUSH || func == fct_pkg::FUNC_UNUSED ||
						    (func == fct_pkg::FUNC_OBSERVE && byte_count == 16'd0))
							state_q <= S_DONE;
						else
							state_q <= S_FIND;
					end
				end
				S_FIND: begin
					if (sts.hit || sts.scan_last) begin
						if (func_q == fct_pkg::FUNC_RELEASE || sts.hit)
							state_q <= S_DONE;
						else if (sts.full)
							state_q <= S_HASH;
						else
							state_q <= S_FREE;
					end
				end
				S_HASH: state_q <= S_HASHN;
				S_HASHN: state_q <= S_RECL;
				S_RECL: begin
					if (sts.scan_last)
						state_q <= S_OLD;
				end
				S_OLD: state_q <= S_FREE;
				S_FREE: begin
					if (!sts.full && (sts.free_found || sts.scan_last))
						state_q <= S_DONE;
					else if (sts.full)
						state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
					out_valid <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid && !in_stall;
				cmd.scan_clear = 1'b1;
			end
			S_FIND: begin
				cmd.find_step = 1'b1;
				cmd.release_hit = func_q == fct_pkg::FUNC_RELEASE && sts.hit;
				cmd.scan_clear = sts.hit || sts.scan_last;
			end
			S_HASH, S_HASHN: begin
				cmd.hash_step = 1'b1;
				cmd.scan_clear = 1'b1;
			end
			S_RECL: begin
				cmd.recl_step = 1'b1;
				cmd.scan_clear = sts.scan_last;
			end
			S_OLD: begin
				cmd.evict_old = sts.full && sts.old_found;
				cmd.scan_clear = 1'b1;
			end
			S_FREE: begin
				cmd.scan_step = 1'b1;
				cmd.commit = !sts.full && sts.free_found;
			end
			S_DONE: begin
				cmd.flush = func_q == fct_pkg::FUNC_FLUSH;
				cmd.res_load = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

`ifndef SYNTHESIS
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall) else $error("accepted while busy");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> out_valid) else $error("result not shown");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> !res_pend) else $error("result overwritten");
`endif
endmodule

### src/fct_dpath.sv
`timescale 1ns / 1ps
module fct_dpath #(
	parameter int CONTEXTS = fct_pkg::CONTEXTS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [31:0]   cfg_data,
	input  logic [1:0]    func,
	input  logic [63:0]   flow_id,
	input  logic [15:0]   byte_count,
	input  logic [62:0]   now,
	output logic          status,
	output logic          found,
	output logic          inspect_valid,
	output logic          truncated,
	output logic [15:0]   stored_length,
	output logic [15:0]   accepted_bytes,
	input  fct_pkg::cmd_t cmd,
	output fct_pkg::sts_t sts
);
	localparam int AW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
	localparam int CW = $clog2(CONTEXTS + 1);
	localparam int BW = (fct_pkg::BUCKETS > 1) ? $clog2(fct_pkg::BUCKETS) : 1;
	localparam int EW = $bits(fct_pkg::entry_t);

	logic [31:0] idle_q;
	logic [15:0] budget_q;
	logic [CONTEXTS-1:0] valid_q;
	logic [CW-1:0] live_q;
	logic [63:0] ins_q;
	logic [1:0]  func_q;
	logic [63:0] id_q;
	logic [15:0] bytes_q;
	logic [62:0] now_q;
	logic [AW:0] idx_q;
	logic        rd_ok_q;
	logic [AW-1:0] rd_idx_q;
	logic [AW-1:0] hit_idx_q;
	fct_pkg::entry_t hit_e_q;
	logic        hit_q;
	logic        nroom_q;
	logic [BW-1:0] bkt_q;
	logic        old_q;
	logic [AW-1:0] old_idx_q;
	logic [62:0] old_ls_q;
	logic [63:0] old_ord_q;
	logic        free_q;

	fct_pkg::entry_t rd_e, wr_e;
	logic [EW-1:0] rdata;
	logic we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;

	assign rd_e = fct_pkg::entry_t'(rdata);
	assign raddr = idx_q[AW-1:0];

	fct_ram #(.WIDTH(EW), .DEPTH(CONTEXTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wr_e),
		.raddr(raddr), .rdata(rdata)
	);

	// hash of the read entry or request id, two stages; low product word from 32-bit partials
	logic [31:0] phi_s1, pcr_s1;
	logic [BW-1:0] ebkt_s2;
	logic [63:0] hsrc;
	logic        hv_s1, hv_s2;
	logic [AW-1:0] hidx_s1, hidx_s2;
	fct_pkg::entry_t he_s1, he_s2;
	logic [63:0] plo;
	logic [31:0] pxa, pxb, hsum;
	logic [8:0]  htop;
	assign hsrc = cmd.hash_step ? id_q : rd_e.flow_id;
	assign plo = {32'd0, hsrc[31:0]} * {32'd0, fct_pkg::HASH_MUL_LO};
	assign pxa = hsrc[31:0] * fct_pkg::HASH_MUL_HI;
	assign pxb = hsrc[63:32] * fct_pkg::HASH_MUL_LO;
	assign hsum = phi_s1 + pcr_s1;
	assign htop = hsum[31:fct_pkg::HASH_SHIFT-32];

	always_ff @(posedge clk) begin
		phi_s1 <= plo[63:32];
		pcr_s1 <= pxa + pxb;
		hv_s1 <= rd_ok_q && cmd.recl_step && valid_q[rd_idx_q];
		hidx_s1 <= rd_idx_q;
		he_s1 <= rd_e;
		ebkt_s2 <= BW'(htop % 10'(fct_pkg::BUCKETS));
		hv_s2 <= hv_s1 && valid_q[hidx_s1];
		hidx_s2 <= hidx_s1;
		he_s2 <= he_s1;
		if (cmd.hash_step)
			bkt_q <= BW'(htop % 10'(fct_pkg::BUCKETS));
	end

	logic idle_e, older_e;
	assign idle_e = now_q >= he_s2.last_seen &&
		(now_q - he_s2.last_seen) > {31'd0, idle_q};
	assign older_e = !old_q || he_s2.last_seen < old_ls_q ||
		(he_s2.last_seen == old_ls_q && he_s2.order > old_ord_q);
	logic rc_hit;
	assign rc_hit = hv_s2 && ebkt_s2 == bkt_q;

	logic [AW:0] last_idx;
	assign last_idx = cmd.recl_step ? (AW+1)'(CONTEXTS + 2) : (AW+1)'(CONTEXTS);
	assign sts.scan_last = idx_q == last_idx;
	assign sts.hit = rd_ok_q && valid_q[rd_idx_q] && rd_e.flow_id == id_q && cmd.find_step;
	assign sts.full = live_q >= CW'(CONTEXTS);
	assign sts.free_found = rd_ok_q && !valid_q[rd_idx_q];
	assign sts.old_found = old_q;

	// budget arithmetic on the entry being written
	fct_pkg::entry_t base_e;
	logic [15:0] space, take;
	logic clip;
	always_comb begin
		base_e = hit_q ? hit_e_q : '0;
		if (!hit_q) begin
			base_e.flow_id = id_q;
			base_e.order = ins_q;
		end
		space = (base_e.length >= budget_q) ? 16'd0 : budget_q - base_e.length;
		clip = bytes_q > space;
		take = clip ? space : bytes_q;
		wr_e = base_e;
		wr_e.last_seen = now_q;
		wr_e.length = base_e.length + take;
		wr_e.clipped = base_e.clipped | clip;
	end

	logic commit_hit;
	assign commit_hit = cmd.res_load && hit_q && func_q == fct_pkg::FUNC_OBSERVE &&
		bytes_q != 16'd0;
	assign we = cmd.commit || commit_hit;
	assign waddr = cmd.commit ? rd_idx_q : hit_idx_q;

	// counters, registers, valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= fct_pkg::IDLE_TIMEOUT_RESET;
			budget_q <= fct_pkg::BYTE_BUDGET_RESET;
			valid_q <= '0;
			live_q <= '0;
			ins_q <= '0;
			idx_q <= '0;
			rd_ok_q <= 1'b0;
			hit_q <= 1'b0;
			nroom_q <= 1'b0;
			old_q <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == fct_pkg::REG_IDLE_TIMEOUT)
				idle_q <= cfg_data;
			if (cfg_we && cfg_index == fct_pkg::REG_BYTE_BUDGET)
				budget_q <= cfg_data[15:0];
			rd_ok_q <= !cmd.scan_clear && idx_q < (AW+1)'(CONTEXTS);
			if (cmd.scan_clear)
				idx_q <= '0;
			else if (idx_q != last_idx)
				idx_q <= idx_q + 1'b1;
			if (cmd.load) begin
				hit_q <= 1'b0;
				nroom_q <= 1'b0;
				old_q <= 1'b0;
				free_q <= 1'b0;
			end
			if (sts.hit)
				hit_q <= 1'b1;
			if (cmd.release_hit) begin
				valid_q[rd_idx_q] <= 1'b0;
				live_q <= live_q - 1'b1;
			end
			if (rc_hit) begin
				if (idle_e) begin
					valid_q[hidx_s2] <= 1'b0;
					live_q <= live_q - 1'b1;
				end else if (older_e) begin
					old_q <= 1'b1;
				end
			end
			if (cmd.evict_old) begin
				valid_q[old_idx_q] <= 1'b0;
				live_q <= live_q - 1'b1;
			end
			if (cmd.scan_step && sts.full)
				nroom_q <= 1'b1;
			if (cmd.scan_step && !sts.full && sts.scan_last && !sts.free_found && !free_q)
				nroom_q <= 1'b1;
			if (cmd.commit) begin
				valid_q[rd_idx_q] <= 1'b1;
				live_q <= live_q + 1'b1;
				ins_q <= ins_q + 64'd1;
				free_q <= 1'b1;
			end
			if (cmd.flush) begin
				valid_q <= '0;
				live_q <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_q <= raddr;
		if (cmd.load) begin
			func_q <= func;
			id_q <= flow_id;
			bytes_q <= byte_count;
			now_q <= now;
		end
		if (sts.hit) begin
			hit_idx_q <= rd_idx_q;
			hit_e_q <= rd_e;
		end
		if (rc_hit && !idle_e && older_e) begin
			old_idx_q <= hidx_s2;
			old_ls_q <= he_s2.last_seen;
			old_ord_q <= he_s2.order;
		end
	end

	// result: for a fresh insert the entry is rebuilt from the committed values
	logic [15:0] new_take;
	logic new_clip;
	logic [15:0] new_space;
	assign new_space = budget_q;
	assign new_clip = bytes_q > new_space;
	assign new_take = new_clip ? new_space : bytes_q;

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status <= 1'b0; found <= 1'b0; inspect_valid <= 1'b0;
			truncated <= 1'b0; stored_length <= '0; accepted_bytes <= '0;
			if (func_q == fct_pkg::FUNC_RELEASE) begin
				found <= hit_q;
			end else if (func_q == fct_pkg::FUNC_OBSERVE && bytes_q != 16'd0) begin
				inspect_valid <= 1'b1;
				if (hit_q) begin
					found <= 1'b1;
					truncated <= wr_e.clipped;
					stored_length <= wr_e.length;
					accepted_bytes <= take;
				end else if (nroom_q || !free_q) begin
					status <= 1'b1;
					truncated <= 1'b1;
				end else begin
					truncated <= new_clip;
					stored_length <= new_take;
					accepted_bytes <= new_take;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CW'(CONTEXTS)) else $error("live count overflow");
	a_live_match: assert property (@(posedge clk) disable iff (!arst_n)
		CW'($countones(valid_q)) == live_q) else $error("live count mismatch");
	a_flush_clr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> live_q == '0) else $error("flush left entries");
`endif
endmodule

### src/flow_context_table_evict_core.sv
`timescale 1ns / 1ps
// flush, ignored and zero-byte items go straight to the result; release and observe first
// walk the table for the flow; an observe miss then scans for a free entry; with the table
// full it first reclaims idle entries of its hash bucket, then evicts the oldest if still full
// throughput: one item at a time, set by the serial walk of the entry ram one entry per cycle
// reset: arst_n clears valid bits, live and insert counters, config to reset values
// entry ram contents are not cleared; an entry's contents are used only while it is valid
module flow_context_table_evict_core #(
	parameter int CONTEXTS = fct_pkg::CONTEXTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [63:0] flow_id,
	input  logic [15:0] byte_count,
	input  logic [62:0] now,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic        found,
	output logic        inspect_valid,
	output logic        truncated,
	output logic [15:0] stored_length,
	output logic [15:0] accepted_bytes
);
	fct_pkg::cmd_t cmd;
	fct_pkg::sts_t sts;

	fct_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.func(func), .byte_count(byte_count), .out_valid(out_valid),
		.out_stall(out_stall), .cmd(cmd), .sts(sts)
	);

	fct_dpath #(.CONTEXTS(CONTEXTS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .func(func), .flow_id(flow_id),
		.byte_count(byte_count), .now(now), .status(status), .found(found),
		.inspect_valid(inspect_valid), .truncated(truncated),
		.stored_length(stored_length), .accepted_bytes(accepted_bytes),
		.cmd(cmd), .sts(sts)
	);
endmodule
